[hw/rtl/sparse_set_membership_macros.svh]
// Assertion macros shared by the sparse-set membership RTL.
`ifndef SPARSE_SET_MEMBERSHIP_MACROS_SVH
`define SPARSE_SET_MEMBERSHIP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssm_pkg.sv]
// Package: field widths and operation/status codes of the sparse-set membership block.
package ssm_pkg;

    localparam int unsigned CAPACITY_DEFAULT = 256;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

[hw/rtl/ssm_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface ssm_req_if;
    logic                        valid;
    logic                        ready;
    logic [ssm_pkg::MODE_W-1:0]  mode;
    logic [ssm_pkg::ID_W-1:0]    member_id;

    modport source (output valid, output mode, output member_id, input ready);
    modport sink   (input valid, input mode, input member_id, output ready);
endinterface

interface ssm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ssm_pkg::STATUS_W-1:0]  status;
    logic [ssm_pkg::POS_W-1:0]     position;
    logic [ssm_pkg::COUNT_W-1:0]   member_count;

    modport source (output valid, output status, output position, output member_count,
                    input ready);
    modport sink   (input valid, input status, input position, input member_count,
                    output ready);
endinterface

[hw/rtl/ssm_sparse_ram.sv]
// Sparse index memory: one write port, one registered read port.
module ssm_sparse_ram #(
    parameter int unsigned DEPTH = ssm_pkg::CAPACITY_DEFAULT,
    parameter int unsigned WIDTH = $clog2(ssm_pkg::CAPACITY_DEFAULT)
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ssm_dense_ram.sv]
// Dense list memory: one write port, two registered read ports with a shared enable.
module ssm_dense_ram #(
    parameter int unsigned DEPTH = ssm_pkg::CAPACITY_DEFAULT,
    parameter int unsigned WIDTH = $clog2(ssm_pkg::CAPACITY_DEFAULT)
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hw/rtl/sparse_set_membership.sv]
// Top level: sparse-set membership engine with sparse/dense memories and a three-step sequencer.
//
// Keeps a set of distinct ids below CAPACITY in two synchronous memories: the dense
// list packs the members in slots 0..count-1, and the sparse index maps each id to
// the slot where it was last placed. Each request transfer adds, finds or removes
// one id and yields exactly one response transfer with a status (0 success/found,
// 1 already present/absent, set full or unused mode, 2 id out of range), the
// dense slot on success and the member count after the request. Remove moves the
// last dense entry into the freed slot and repoints its sparse entry. Each request
// goes through these steps: the accept cycle reads the sparse index, the next reads
// both dense ports (the id's slot and the last slot), the last checks membership and
// writes back to both memories; the following request is accepted in the cycle after
// write-back. The dependent reads (sparse then dense) fix this order. A finished
// response waits in an output register, so a new request is taken while it waits;
// the write-back step holds only if an earlier response is still not taken.
// After reset the block clears the sparse index, one entry per cycle, and accepts
// no request until that pass is done.
`include "sparse_set_membership_macros.svh"

module sparse_set_membership #(
    parameter int unsigned CAPACITY = ssm_pkg::CAPACITY_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    ssm_req_if.sink    req,
    ssm_rsp_if.source  rsp
);

    localparam int unsigned IDX_W  = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned IDW1   = ssm_pkg::ID_W + 1;
    localparam logic [CNT_W-1:0]          CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [ssm_pkg::ID_W:0]    CAP_ID   = IDW1'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SPARSE,
        S_DENSE
    } state_t;

    typedef struct packed {
        logic [ssm_pkg::STATUS_W-1:0] status;
        logic [ssm_pkg::POS_W-1:0]    position;
        logic [ssm_pkg::COUNT_W-1:0]  member_count;
    } result_t;

    // sequencer state and request latch
    state_t                      state_reg, state_next;
    logic [ssm_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [ssm_pkg::ID_W-1:0]    id_reg, id_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    // clearing pass over the sparse index
    logic                        clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0]            clr_idx_reg, clr_idx_next;

    // response register
    logic                        out_valid_reg, out_valid_next;
    result_t                     res_reg, res_next;

    // memory ports
    logic             sp_we, sp_re;
    logic [IDX_W-1:0] sp_waddr, sp_wdata, sp_raddr, sp_rdata;
    logic             dn_we, dn_re;
    logic [IDX_W-1:0] dn_waddr, dn_wdata, dn_rdata_a, dn_rdata_b;
    logic [IDX_W-1:0] last_slot;

    // operation write-back, merged with the clearing pass on the sparse port
    logic             op_sp_we;
    logic [IDX_W-1:0] op_sp_waddr, op_sp_wdata;

    logic accept;
    logic finish;
    logic in_range;
    logic found;
    logic full;
    logic [IDX_W-1:0] id_idx;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !clr_busy_reg;

    // write-back may go ahead once the response register is free
    assign finish    = (state_reg == S_DENSE) && (!out_valid_reg || rsp.ready);

    assign id_idx    = id_reg[IDX_W-1:0];
    assign in_range  = {1'b0, id_reg} < CAP_ID;
    assign full      = count_reg == CAP_CNT;
    // the id is a member when its sparse slot is live and the dense entry there matches
    assign found     = in_range && (CNT_W'(sp_rdata) < count_reg) && (dn_rdata_a == id_idx);
    assign last_slot = IDX_W'(count_reg - 1'b1);

    // read addressing: sparse on accept, both dense ports in the cycle after
    assign sp_re    = accept;
    assign sp_raddr = req.member_id[IDX_W-1:0];
    assign dn_re    = (state_reg == S_SPARSE);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        clr_busy_next  = clr_busy_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        op_sp_we       = 1'b0;
        op_sp_waddr    = id_idx;
        op_sp_wdata    = count_reg[IDX_W-1:0];
        dn_we          = 1'b0;
        dn_waddr       = count_reg[IDX_W-1:0];
        dn_wdata       = id_idx;

        // advance the clearing pass
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_busy_next = 1'b0;
            end
        end

        // drop the response once taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = req.mode;
                    id_next    = req.member_id;
                    state_next = S_SPARSE;
                end
            end
            S_SPARSE:
            begin
                state_next = S_DENSE;
            end
            S_DENSE:
            begin
                if (finish)
                begin
                    res_next.status   = ssm_pkg::ST_MISS;
                    res_next.position = '0;
                    if (!in_range)
                    begin
                        res_next.status = ssm_pkg::ST_RANGE;
                    end
                    else
                    begin
                        case (mode_reg)
                            ssm_pkg::MODE_ADD:
                            begin
                                if (!found && !full)
                                begin
                                    // append at the end of the dense list
                                    dn_we             = 1'b1;
                                    op_sp_we          = 1'b1;
                                    count_next        = CNT_W'(count_reg + 1'b1);
                                    res_next.status   = ssm_pkg::ST_OK;
                                    res_next.position = ssm_pkg::POS_W'(count_reg);
                                end
                            end
                            ssm_pkg::MODE_FIND:
                            begin
                                if (found)
                                begin
                                    res_next.status   = ssm_pkg::ST_OK;
                                    res_next.position = ssm_pkg::POS_W'(sp_rdata);
                                end
                            end
                            ssm_pkg::MODE_REMOVE:
                            begin
                                if (found)
                                begin
                                    // move the last member into the freed slot
                                    dn_we             = 1'b1;
                                    dn_waddr          = sp_rdata;
                                    dn_wdata          = dn_rdata_b;
                                    op_sp_we          = 1'b1;
                                    op_sp_waddr       = dn_rdata_b;
                                    op_sp_wdata       = sp_rdata;
                                    count_next        = CNT_W'(count_reg - 1'b1);
                                    res_next.status   = ssm_pkg::ST_OK;
                                    res_next.position = ssm_pkg::POS_W'(sp_rdata);
                                end
                            end
                            default:
                            begin
                                res_next.status = ssm_pkg::ST_MISS;
                            end
                        endcase
                    end
                    res_next.member_count = ssm_pkg::COUNT_W'(count_next);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the clearing pass owns the sparse write port until it ends
    assign sp_we    = clr_busy_reg || op_sp_we;
    assign sp_waddr = clr_busy_reg ? clr_idx_reg : op_sp_waddr;
    assign sp_wdata = clr_busy_reg ? '0 : op_sp_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= '0;
            id_reg        <= '0;
            count_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            id_reg        <= id_next;
            count_reg     <= count_next;
            clr_busy_reg  <= clr_busy_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = res_reg.status;
    assign rsp.position     = res_reg.position;
    assign rsp.member_count = res_reg.member_count;

    ssm_sparse_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (IDX_W)
    ) u_sparse (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    ssm_dense_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (IDX_W)
    ) u_dense (
        .clk     (clk),
        .we      (dn_we),
        .waddr   (dn_waddr),
        .wdata   (dn_wdata),
        .re      (dn_re),
        .raddr_a (sp_rdata),
        .raddr_b (last_slot),
        .rdata_a (dn_rdata_a),
        .rdata_b (dn_rdata_b)
    );

    `SSM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP_CNT, "member count above capacity")
    `SSM_ASSERT_NEXT(a_add_grows,
        finish && mode_reg == ssm_pkg::MODE_ADD && res_next.status == ssm_pkg::ST_OK,
        count_reg == CNT_W'($past(count_reg) + 1'b1),
        "successful add did not grow count")
    `SSM_ASSERT_NEXT(a_remove_shrinks,
        finish && mode_reg == ssm_pkg::MODE_REMOVE && res_next.status == ssm_pkg::ST_OK,
        count_reg == CNT_W'($past(count_reg) - 1'b1),
        "successful remove did not shrink count")
    `SSM_ASSERT_NOW(a_write_phase, sp_we || dn_we, clr_busy_reg || finish,
        "memory write outside write-back or clearing")

endmodule

[verif/ssm_checker.sv]
// Scoreboard for the sparse-set block: mirrors the set, predicts each response and compares.
module ssm_checker #(
    parameter int unsigned CAPACITY = ssm_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    ssm_req_if          req,
    ssm_rsp_if          rsp,
    output int unsigned mismatches,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssm_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  member_count;
    } member_result_t;

    logic [POS_W-1:0]   dense_mirror  [CAPACITY];
    logic [POS_W-1:0]   sparse_mirror [CAPACITY];
    logic [COUNT_W-1:0] set_size;
    member_result_t     awaited_q [$];

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            dense_mirror[i]  = '0;
            sparse_mirror[i] = '0;
        end
        set_size   = '0;
        mismatches = 0;
        pending    = 0;
    end

    // Apply one request to the mirrored set and return the response it must produce.
    function automatic member_result_t predict_response(input logic [MODE_W-1:0] mode,
                                                        input logic [ID_W-1:0]   id);
        member_result_t   res;
        logic [POS_W-1:0] slot;
        logic [POS_W-1:0] last;
        logic             present;
        res.status   = ST_MISS;
        res.position = '0;
        if (id >= CAPACITY)
        begin
            res.status = ST_RANGE;
        end
        else
        begin
            slot    = sparse_mirror[id];
            present = (slot < set_size) && (dense_mirror[slot] == id);
            case (mode)
                MODE_ADD:
                begin
                    if (!present && set_size < CAPACITY)
                    begin
                        dense_mirror[set_size] = id[POS_W-1:0];
                        sparse_mirror[id]      = set_size[POS_W-1:0];
                        res.status             = ST_OK;
                        res.position           = set_size[POS_W-1:0];
                        set_size               = set_size + 1'b1;
                    end
                end
                MODE_FIND:
                begin
                    if (present)
                    begin
                        res.status   = ST_OK;
                        res.position = slot;
                    end
                end
                MODE_REMOVE:
                begin
                    if (present)
                    begin
                        // the last member fills the freed slot
                        last                = dense_mirror[set_size - 1'b1];
                        dense_mirror[slot]  = last;
                        sparse_mirror[last] = slot;
                        set_size            = set_size - 1'b1;
                        res.status          = ST_OK;
                        res.position        = slot;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.member_count = set_size;
        return res;
    endfunction

    function automatic int field_differs(input string name, input int exp_v, input int act_v);
        if (exp_v == act_v)
            return 0;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge clk)
    begin : watch
        member_result_t awaited;
        int             errs;
        errs = 0;
        if (rst_n)
        begin
            // responses first: a request taken at this edge cannot be answered at it
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_q.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none actual %0d/%0d/%0d",
                             $time, rsp.status, rsp.position, rsp.member_count);
                    errs = 1;
                end
                else
                begin
                    awaited = awaited_q.pop_front();
                    errs += field_differs("status", awaited.status, rsp.status);
                    errs += field_differs("position", awaited.position, rsp.position);
                    errs += field_differs("member_count", awaited.member_count,
                                          rsp.member_count);
                end
            end
            if (req.valid && req.ready)
                awaited_q.push_back(predict_response(req.mode, req.member_id));
            pending    <= awaited_q.size();
            mismatches <= mismatches + errs;
        end
    end

endmodule

[verif/sparse_set_membership_tb.sv]
// Testbench top: drives requests, paces responses and prints the verdict.
module sparse_set_membership_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssm_pkg::*;

    // mode 3 has no operation behind it; the block must answer it as a miss when the id is in range
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Slowest correct run: the clearing pass, then per item the sender's idle burst,
    // the receiver's stall burst and the block's own work, for roughly 500 items,
    // plus the long hold-off and the drain pause; take ten times that.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned CALM_ITEMS   = 30;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned pending;
    int unsigned cycle_count = 0;

    // calm: no idling on either side; hold_off_request: ask the receiver for one long stall
    bit calm             = 1'b0;
    bit hold_off_request = 1'b0;

    ssm_req_if req ();
    ssm_rsp_if rsp ();

    sparse_set_membership dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ssm_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5ns clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Response side: mostly ready, with random stall bursts
    // and one long hold-off on request so the block backs up into its input.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                // low for a random stall burst
                rsp.ready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the transfer. An optional idle burst goes
    // first; valid is only lowered for a burst, so back-to-back items keep it high.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= mode;
        req.member_id <= id;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Drop valid and hold the sender until every response has come back.
    task automatic drain_responses();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly ids from a small pool so that adds, finds and removes collide,
    // with some spread over the whole range and some past capacity.
    function automatic logic [ID_W-1:0] pick_id(input int unsigned pool_hi);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return ID_W'($urandom_range(0, pool_hi));
        if (roll < 88)
            return ID_W'($urandom_range(0, CAPACITY_DEFAULT - 1));
        if (roll < 95)
            return ID_W'($urandom_range(CAPACITY_DEFAULT, 65535));
        return ID_W'($urandom);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return MODE_ADD;
        if (roll < 65)
            return MODE_FIND;
        if (roll < 95)
            return MODE_REMOVE;
        return MODE_UNUSED;
    endfunction

    initial
    begin : stimulus
        int order [CAPACITY_DEFAULT];
        int pick;
        int tmp;

        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.mode      = MODE_ADD;
        req.member_id = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty-set lookups, the id extremes, already present,
        // stale sparse pointers, remove of the first and the last member,
        // out-of-range ids in every mode, and the unused mode.
        send_item(MODE_FIND, 16'd0);
        send_item(MODE_REMOVE, 16'd5);
        send_item(MODE_ADD, 16'd0);
        send_item(MODE_ADD, 16'd255);
        send_item(MODE_ADD, 16'd0);
        send_item(MODE_FIND, 16'd255);
        send_item(MODE_FIND, 16'd0);
        send_item(MODE_ADD, 16'd128);
        send_item(MODE_FIND, 16'd7);
        send_item(MODE_REMOVE, 16'd0);
        send_item(MODE_FIND, 16'd128);
        send_item(MODE_FIND, 16'd0);
        send_item(MODE_REMOVE, 16'd128);
        send_item(MODE_REMOVE, 16'd255);
        send_item(MODE_REMOVE, 16'd255);
        send_item(MODE_ADD, 16'd256);
        send_item(MODE_FIND, 16'hFFFF);
        send_item(MODE_REMOVE, 16'h8000);
        send_item(MODE_UNUSED, 16'hFFFF);
        send_item(MODE_UNUSED, 16'd10);
        send_item(MODE_ADD, 16'd1);
        send_item(MODE_UNUSED, 16'd1);
        send_item(MODE_REMOVE, 16'd1);

        // Random churn over a small pool keeps the set small and busy.
        repeat (80)
            send_item(pick_mode(), pick_id(15));

        // Pause the sender until the block has answered everything.
        drain_responses();

        // Fill the set completely in shuffled order; earlier members come back
        // as already present, and the last successful add lands in the top slot.
        for (int i = 0; i < CAPACITY_DEFAULT; i++)
            order[i] = i;
        for (int i = CAPACITY_DEFAULT - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        foreach (order[i])
            send_item(MODE_ADD, ID_W'(order[i]));

        // Full set: adding again must miss, finds must hit.
        send_item(MODE_ADD, ID_W'($urandom_range(0, CAPACITY_DEFAULT - 1)));
        send_item(MODE_FIND, ID_W'($urandom_range(0, CAPACITY_DEFAULT - 1)));
        send_item(MODE_ADD, 16'd256);

        // Long receiver hold-off while requests keep coming.
        hold_off_request = 1'b1;
        repeat (90)
            send_item(pick_mode(), pick_id(CAPACITY_DEFAULT - 1));

        // Final stretch with no idling on either side.
        calm = 1'b1;
        repeat (CALM_ITEMS)
            send_item(pick_mode(), pick_id(31));

        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
